FILE: sv/nljr_pkg.sv
// ----------------------------------------------------------------------------
// nljr_pkg
// Shared types and constants for the nearest label jump resolver.
// ----------------------------------------------------------------------------
package nljr_pkg;

    localparam int MAX_LABELS  = 64;
    localparam int MAX_PROGRAM = 1024;

    localparam int POS_W   = 10;
    localparam int TAG_W   = 8;
    localparam int LEN_W   = 11;
    localparam int DIST_W  = 4;
    localparam int CNT_W   = $clog2(MAX_LABELS + 1);
    localparam int STEP_W  = $clog2(POS_W);
    localparam int SHIFT_W = LEN_W + POS_W - 1;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              load;
        logic [POS_W-1:0]  jpos;
        logic              fwd;
        logic              step;
        logic [POS_W-1:0]  div;
        logic              div_big;
        logic [LEN_W-1:0]  len;
        logic [TAG_W-1:0]  qtag;
    } ctl_t;

    // running best, passed cell to cell
    typedef struct packed {
        logic              valid;
        logic [CNT_W-1:0]  left;
        logic              have;
        logic [DIST_W-1:0] best_t;
        logic [POS_W-1:0]  best_d;
        logic [POS_W-1:0]  best_pos;
    } tok_t;

    function automatic logic [DIST_W-1:0] popcount8(input logic [TAG_W-1:0] v);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < TAG_W; i++)
        begin
            n = n + DIST_W'(v[i]);
        end
        return n;
    endfunction

endpackage

FILE: sv/nljr_cell.sv
// ----------------------------------------------------------------------------
// nljr_cell
// One label entry: while step is asserted, reduces its jump distance mod length
// one bit per cycle, then scores itself against the passing token and forwards the best.
// ----------------------------------------------------------------------------
module nljr_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  nljr_pkg::ctl_t            ctl,
    input  logic                      wr_en,
    input  logic [nljr_pkg::POS_W-1:0] wr_pos,
    input  logic [nljr_pkg::TAG_W-1:0] wr_tag,
    input  nljr_pkg::tok_t            tok_in,
    output nljr_pkg::tok_t            tok_out
);
    import nljr_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [POS_W-1:0]  x_reg;
    logic              neg_reg;
    tok_t              tok_reg;
    tok_t              tok_next;

    logic [POS_W:0]    diff;
    logic [POS_W:0]    mag;
    logic [POS_W-1:0]  resid;
    logic [LEN_W-1:0]  comp;
    logic [DIST_W-1:0] t;
    logic              better;

    always_comb
    begin
        if (ctl.fwd)
        begin
            diff = {1'b0, pos_reg} - {1'b0, ctl.jpos};
        end
        else
        begin
            diff = {1'b0, ctl.jpos} - {1'b0, pos_reg};
        end
        mag = diff[POS_W] ? (~diff + 1'b1) : diff;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_reg <= wr_pos;
            tag_reg <= wr_tag;
        end
        if (ctl.load)
        begin
            x_reg   <= mag[POS_W-1:0];
            neg_reg <= diff[POS_W];
        end
        else if (ctl.step && !ctl.div_big && x_reg >= ctl.div)
        begin
            x_reg <= x_reg - ctl.div;
        end
    end

    always_comb
    begin
        comp  = ctl.len - {1'b0, x_reg};
        resid = (neg_reg && x_reg != '0) ? comp[POS_W-1:0] : x_reg;
        t     = popcount8(tag_reg ^ ctl.qtag);
        better = !tok_in.have || t < tok_in.best_t ||
                 (t == tok_in.best_t && resid < tok_in.best_d);
        tok_next = tok_in;
        if (tok_in.valid && tok_in.left != '0)
        begin
            tok_next.left = tok_in.left - 1'b1;
            if (better)
            begin
                tok_next.have     = 1'b1;
                tok_next.best_t   = t;
                tok_next.best_d   = resid;
                tok_next.best_pos = pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: sv/nearest_label_jump_resolver.sv
// ----------------------------------------------------------------------------
// nearest_label_jump_resolver
// Label table as a row of cells; queries pick the closest-tag, nearest label.
// ----------------------------------------------------------------------------
// Clear and add beats are accepted back to back.
// Query: distance reduction in ST_MOD (one quotient bit per cycle in every
// cell), a launch in ST_LAUNCH, then the token walks the cell row in ST_SCAN,
// and ST_DONE loads the output register once the output is free.
// One query in flight; the input stalls until its result is registered.
// Reset empties the table and sets program length to 1024; no clearing pass.
module nearest_label_jump_resolver
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [nljr_pkg::LEN_W-1:0]  cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [nljr_pkg::POS_W-1:0]  position,
    input  logic [nljr_pkg::TAG_W-1:0]  tag,
    input  logic                        direction_down,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [nljr_pkg::POS_W-1:0]  target_position,
    output logic                        found,
    output logic [nljr_pkg::DIST_W-1:0] tag_distance
);
    import nljr_pkg::*;

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_MOD    = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   len_reg;
    logic [STEP_W-1:0]  k_reg, k_next;
    logic [TAG_W-1:0]   qtag_reg;
    logic [POS_W-1:0]   qpos_reg;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   tpos_reg;
    logic               found_reg;
    logic [DIST_W-1:0]  tdist_reg;
    tok_t               res_reg;

    logic               acc;
    logic               add_acc;
    logic               out_free;
    logic [SHIFT_W-1:0] shifted;
    ctl_t               ctl;
    tok_t               launch_tok;
    tok_t               chain [MAX_LABELS+1];
    logic [MAX_LABELS-1:0] wr_en;

    assign acc      = in_valid && !in_stall;
    assign add_acc  = acc && opcode == OP_ADD && count_reg < CNT_W'(MAX_LABELS);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign shifted  = SHIFT_W'(len_reg) << k_reg;

    always_comb
    begin
        ctl.load    = acc && opcode == OP_QUERY;
        ctl.jpos    = position;
        ctl.fwd     = direction_down;
        ctl.step    = state_reg == ST_MOD;
        ctl.div     = shifted[POS_W-1:0];
        ctl.div_big = |shifted[SHIFT_W-1:POS_W];
        ctl.len     = len_reg;
        ctl.qtag    = qtag_reg;
    end

    always_comb
    begin
        launch_tok          = '0;
        launch_tok.valid    = state_reg == ST_LAUNCH;
        launch_tok.left     = count_reg;
        launch_tok.best_pos = qpos_reg;
    end

    assign chain[0] = launch_tok;

    for (genvar i = 0; i < MAX_LABELS; i++)
    begin : g_cell
        assign wr_en[i] = add_acc && count_reg == CNT_W'(i);

        nljr_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .wr_en   (wr_en[i]),
            .wr_pos  (position),
            .wr_tag  (tag),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (opcode)
                        OP_CLEAR: count_next = '0;
                        OP_ADD:
                        begin
                            if (add_acc)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            state_next = ST_MOD;
                            k_next     = STEP_W'(POS_W - 1);
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD:
            begin
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    state_next = ST_LAUNCH;
                end
            end
            ST_LAUNCH: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (chain[MAX_LABELS].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            len_reg       <= LEN_W'(MAX_PROGRAM);
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                if (cfg_write_data == '0)
                begin
                    len_reg <= LEN_W'(1);
                end
                else if (cfg_write_data > LEN_W'(MAX_PROGRAM))
                begin
                    len_reg <= LEN_W'(MAX_PROGRAM);
                end
                else
                begin
                    len_reg <= cfg_write_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            qtag_reg <= tag;
            qpos_reg <= position;
        end
        if (state_reg == ST_SCAN && chain[MAX_LABELS].valid)
        begin
            res_reg <= chain[MAX_LABELS];
        end
        if (state_reg == ST_DONE && out_free)
        begin
            tpos_reg  <= res_reg.best_pos;
            found_reg <= res_reg.have;
            tdist_reg <= res_reg.have ? res_reg.best_t : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign target_position = tpos_reg;
    assign found           = found_reg;
    assign tag_distance    = tdist_reg;

    a_exit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[MAX_LABELS].valid |-> state_reg == ST_SCAN)
        else $error("token left the cell row outside scan");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LABELS))
        else $error("entry count beyond capacity");

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        acc && opcode == OP_QUERY |=> state_reg == ST_MOD)
        else $error("query beat did not start reduction");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tag_distance <= DIST_W'(TAG_W) && (found || tag_distance == '0))
        else $error("tag distance out of range");

endmodule
